>>> rtl/core/sscb_pkg.sv
`timescale 1ns / 1ps
// Package for the sharded statistics counter bank.
// Field widths, opcodes, controller states and parameter defaults.
// No dependencies.
package sscb_pkg;

  localparam int unsigned WORD_W   = 64;
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned SHARD_W  = 3;
  localparam int unsigned CIDX_W   = 6;
  localparam int unsigned DELTA_W  = 32;
  localparam int unsigned ACTIVE_W = 4;

  localparam int unsigned MAX_SHARDS_DEF = 8;
  localparam int unsigned COUNTERS_DEF   = 64;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 4'd1;

  localparam logic [OPCODE_W-1:0] OP_ADD      = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ     = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ_CLR = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_READ,
    ST_ZERO
  } state_t;

endpackage

>>> rtl/core/sscb_if.sv
`timescale 1ns / 1ps
// Channel interfaces for the sharded statistics counter bank.
// Depends on sscb_pkg for field widths.
interface sscb_req_if;
  logic                            valid;
  logic                            ready;
  logic [sscb_pkg::OPCODE_W-1:0]   opcode;
  logic [sscb_pkg::SHARD_W-1:0]    shard_index;
  logic [sscb_pkg::CIDX_W-1:0]     counter_index;
  logic signed [sscb_pkg::DELTA_W-1:0] delta;

  modport source (output valid, opcode, shard_index, counter_index, delta, input ready);
  modport sink (input valid, opcode, shard_index, counter_index, delta, output ready);
endinterface

interface sscb_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sscb_pkg::WORD_W-1:0]   value;

  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface

interface sscb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sscb_pkg::ACTIVE_W-1:0]  active_shards;

  modport source (output valid, active_shards, input ready);
  modport sink (input valid, active_shards, output ready);
endinterface

>>> rtl/core/sharded_stats_counter_bank_top.sv
`timescale 1ns / 1ps
// Sharded statistics counter bank: controller around one counter memory.
// Depends on sscb_pkg, sscb_if (channels) and sscb_mem.
//
//  channel | dir | payload                                        | handshake
//  req     | in  | opcode, shard_index, counter_index, delta      | valid/ready
//  rsp     | out | value                                          | valid/ready
//  cfg     | in  | active_shards                                  | valid/ready
//
// Add: memory read, then add and write back. Read and read-clear: one memory
// read per shard slice, walked in order over the active shards, the clear
// written back slice by slice. Dropped items return a zero result.
// After reset a clearing pass writes zero to every memory word (512 words by
// default); req is not ready then. A finishing item waits while rsp holds an
// untaken result.
module sharded_stats_counter_bank_top #(
  parameter int unsigned MAX_SHARDS = sscb_pkg::MAX_SHARDS_DEF,
  parameter int unsigned COUNTERS   = sscb_pkg::COUNTERS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  sscb_req_if.sink   req,
  sscb_rsp_if.source rsp,
  sscb_cfg_if.sink   cfg
);

  localparam int unsigned SHW = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;
  localparam int unsigned CW  = (COUNTERS > 1) ? $clog2(COUNTERS) : 1;
  localparam int unsigned AW  = SHW + CW;
  localparam int unsigned W   = sscb_pkg::WORD_W;

  sscb_pkg::state_t state, state_next;

  logic [sscb_pkg::ACTIVE_W-1:0] active_shards;
  logic [sscb_pkg::ACTIVE_W-1:0] eff;
  logic [SHW-1:0]                s, s_next;
  logic [CW-1:0]                 cidx, cidx_next;
  logic                          clr, clr_next;
  logic [W-1:0]                  delta_ext, delta_ext_next;
  logic [W-1:0]                  acc, acc_next;
  logic [AW-1:0]                 clr_addr;
  logic                          out_valid, out_valid_next;
  logic [W-1:0]                  out_value, out_value_next;

  logic                          we;
  logic [AW-1:0]                 waddr, raddr;
  logic [W-1:0]                  wdata, rdata;

  logic                          out_free;
  logic                          cidx_ok, shard_ok, last;
  logic [31:0]                   cidx_w, shard_w;
  logic [W-1:0]                  sum;

  sscb_mem #(.AW(AW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Out-of-range active counts clamp to 1..MAX_SHARDS.
  always_comb begin
    if (active_shards == '0) begin
      eff = sscb_pkg::ACTIVE_W'(1);
    end else if (32'(active_shards) > 32'(MAX_SHARDS)) begin
      eff = sscb_pkg::ACTIVE_W'(MAX_SHARDS);
    end else begin
      eff = active_shards;
    end
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_shards <= sscb_pkg::ACTIVE_RST;
    end else if (cfg.valid) begin
      active_shards <= cfg.active_shards;
    end
  end

  assign out_free  = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;
  assign rsp.value = out_value;
  assign req.ready = (state == sscb_pkg::ST_IDLE);

  assign cidx_w   = 32'(req.counter_index);
  assign shard_w  = 32'(req.shard_index);
  assign cidx_ok  = cidx_w < 32'(COUNTERS);
  assign shard_ok = shard_w < 32'(eff);
  assign sum      = (state == sscb_pkg::ST_ADD) ? rdata + delta_ext : acc + rdata;
  assign last     = (32'(s) + 32'd1) == 32'(eff);

  always_comb begin
    state_next     = state;
    s_next         = s;
    cidx_next      = cidx;
    clr_next       = clr;
    delta_ext_next = delta_ext;
    acc_next       = acc;
    out_valid_next = out_valid && !rsp.ready;
    out_value_next = out_value;
    we             = 1'b0;
    waddr          = {s, cidx};
    wdata          = '0;
    raddr          = {s, cidx};

    case (state)
      sscb_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        if (clr_addr == AW'((1 << AW) - 1)) begin
          state_next = sscb_pkg::ST_IDLE;
        end
      end
      sscb_pkg::ST_IDLE: begin
        cidx_next      = cidx_w[CW-1:0];
        delta_ext_next = {{(W - sscb_pkg::DELTA_W){req.delta[sscb_pkg::DELTA_W-1]}},
                          req.delta};
        acc_next       = '0;
        clr_next       = (req.opcode == sscb_pkg::OP_READ_CLR);
        case (req.opcode)
          sscb_pkg::OP_ADD: begin
            s_next = shard_w[SHW-1:0];
          end
          default: begin
            s_next = '0;
          end
        endcase
        raddr = {s_next, cidx_next};
        if (req.valid) begin
          case (req.opcode)
            sscb_pkg::OP_ADD: begin
              state_next = (cidx_ok && shard_ok) ? sscb_pkg::ST_ADD : sscb_pkg::ST_ZERO;
            end
            sscb_pkg::OP_READ, sscb_pkg::OP_READ_CLR: begin
              state_next = cidx_ok ? sscb_pkg::ST_READ : sscb_pkg::ST_ZERO;
            end
            default: begin
              state_next = sscb_pkg::ST_ZERO;
            end
          endcase
        end
      end
      sscb_pkg::ST_ADD: begin
        if (out_free) begin
          we             = 1'b1;
          wdata          = sum;
          out_valid_next = 1'b1;
          out_value_next = sum;
          state_next     = sscb_pkg::ST_IDLE;
        end
      end
      sscb_pkg::ST_READ: begin
        if (!last) begin
          // advance to the next slice, clearing this one on read-clear
          we       = clr;
          acc_next = sum;
          s_next   = s + SHW'(1);
          raddr    = {s_next, cidx};
        end else if (out_free) begin
          we             = clr;
          out_valid_next = 1'b1;
          out_value_next = sum;
          state_next     = sscb_pkg::ST_IDLE;
        end
      end
      sscb_pkg::ST_ZERO: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_value_next = '0;
          state_next     = sscb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sscb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sscb_pkg::ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (state == sscb_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    s         <= s_next;
    cidx      <= cidx_next;
    clr       <= clr_next;
    delta_ext <= delta_ext_next;
    acc       <= acc_next;
    out_value <= out_value_next;
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == sscb_pkg::ST_IDLE || state == sscb_pkg::ST_ZERO) |-> !we)
    else $error("counter memory written outside an update");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != sscb_pkg::ST_IDLE))
    else $error("accepted item did not start");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == sscb_pkg::ST_READ) |-> (32'(s) < 32'(eff)))
    else $error("shard walk past active count");

  a_result_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready && state != sscb_pkg::ST_CLEAR) |=> out_valid)
    else $error("pending result lost");

endmodule

>>> rtl/core/sscb_mem.sv
`timescale 1ns / 1ps
// Counter store: one write port, one read port with registered read data.
// Depends on sscb_pkg for the word width.
module sscb_mem #(
  parameter int unsigned AW = 9
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [sscb_pkg::WORD_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [sscb_pkg::WORD_W-1:0] rdata
);

  localparam int unsigned DEPTH = 1 << AW;

  logic [sscb_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
